// File: hw/rtl/psva_pkg.sv
// ----------------------------------------------------------------------------
// psva_pkg
// Shared types and constants for the power-state vote arbiter.
// ----------------------------------------------------------------------------
package psva_pkg;

    // Defaults for the top-level parameters
    localparam int STATE_COUNT_DEF = 6;
    localparam int COUNT_BITS_DEF  = 16;

    // Fixed field widths
    localparam int STATE_W = 3;
    localparam int MUX_W   = 2;

    // State codes of note
    localparam logic [STATE_W-1:0] STATE_OFF   = 3'd0;
    localparam logic [STATE_W-1:0] STATE_READY = 3'd1;

    // Reset value of the allowed-maximum register
    localparam logic [STATE_W-1:0] MAX_ALLOWED_RST = 3'd5;

    // Clock-mux action codes
    typedef enum logic [MUX_W-1:0] {
        MUX_NONE   = 2'd0,
        MUX_NORMAL = 2'd1,
        MUX_LOW    = 2'd2
    } mux_action_t;

    // Status codes
    typedef enum logic {
        STATUS_OK      = 1'b0,
        STATUS_INVALID = 1'b1
    } status_t;

    // One registered vote item
    typedef struct packed {
        logic               vld;
        logic [STATE_W-1:0] old_state;
        logic               old_aggressor;
        logic [STATE_W-1:0] new_state;
        logic               new_aggressor;
    } vote_t;

endpackage

// File: hw/rtl/psva_counts.sv
// ----------------------------------------------------------------------------
// psva_counts
// Per-state vote counters for both classes, with underflow detection and
// saturating increment. Reports which counts are nonzero after the update.
// ----------------------------------------------------------------------------
module psva_counts
    import psva_pkg::*;
#(
    parameter int STATE_COUNT = STATE_COUNT_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  vote_t                  vote,
    output logic [STATE_COUNT-1:0] aggr_live,
    output logic [STATE_COUNT-1:0] pass_live,
    output logic                   underflow
);

    // Entry 0 (off) is never counted, so it has no counter
    logic [COUNT_BITS-1:0] aggr_cnt_reg  [1:STATE_COUNT-1];
    logic [COUNT_BITS-1:0] aggr_cnt_next [1:STATE_COUNT-1];
    logic [COUNT_BITS-1:0] pass_cnt_reg  [1:STATE_COUNT-1];
    logic [COUNT_BITS-1:0] pass_cnt_next [1:STATE_COUNT-1];
    logic [STATE_COUNT-1:1] aggr_under;
    logic [STATE_COUNT-1:1] pass_under;

    assign aggr_live[0] = 1'b0;
    assign pass_live[0] = 1'b0;
    assign underflow    = |aggr_under | |pass_under;

    for (genvar i = 1; i < STATE_COUNT; i++) begin : g_entry
        logic                  old_hit;
        logic                  new_hit;
        logic [COUNT_BITS-1:0] aggr_mid;
        logic [COUNT_BITS-1:0] pass_mid;

        // Does this item touch entry i?
        assign old_hit = vote.vld && ({{(32-STATE_W){1'b0}}, vote.old_state} == 32'(i));
        assign new_hit = vote.vld && ({{(32-STATE_W){1'b0}}, vote.new_state} == 32'(i));

        // Withdraw first, then add the new vote
        always_comb
        begin
            aggr_under[i] = old_hit && vote.old_aggressor && (aggr_cnt_reg[i] == '0);
            pass_under[i] = old_hit && !vote.old_aggressor && (pass_cnt_reg[i] == '0);

            aggr_mid = aggr_cnt_reg[i];
            if (old_hit && vote.old_aggressor && (aggr_cnt_reg[i] != '0))
            begin
                aggr_mid = aggr_cnt_reg[i] - 1'b1;
            end
            pass_mid = pass_cnt_reg[i];
            if (old_hit && !vote.old_aggressor && (pass_cnt_reg[i] != '0))
            begin
                pass_mid = pass_cnt_reg[i] - 1'b1;
            end

            aggr_cnt_next[i] = aggr_mid;
            if (new_hit && vote.new_aggressor && (aggr_mid != '1))
            begin
                aggr_cnt_next[i] = aggr_mid + 1'b1;
            end
            pass_cnt_next[i] = pass_mid;
            if (new_hit && !vote.new_aggressor && (pass_mid != '1))
            begin
                pass_cnt_next[i] = pass_mid + 1'b1;
            end
        end

        assign aggr_live[i] = (aggr_cnt_next[i] != '0);
        assign pass_live[i] = (pass_cnt_next[i] != '0);

        // Counter registers
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                aggr_cnt_reg[i] <= '0;
                pass_cnt_reg[i] <= '0;
            end
            else
            begin
                aggr_cnt_reg[i] <= aggr_cnt_next[i];
                pass_cnt_reg[i] <= pass_cnt_next[i];
            end
        end
    end

endmodule

// File: hw/rtl/power_state_vote_arbiter_core.sv
// ----------------------------------------------------------------------------
// power_state_vote_arbiter_core
// Tallies power-state votes and picks the winning state and class.
//
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+------------------------------------
//  vote in  | start / busy            | old_state, old_aggressor,
//           |                         | new_state, new_aggressor
//  result   | done (one-cycle strobe) | chosen_state, chosen_aggressor,
//           |                         | change_issued, mux_action, status,
//           |                         | underflow
//  config   | cfg_valid / cfg_ready   | cfg_data (max_allowed_state)
//
// One item per cycle while busy is low; done follows the accepting edge
// through the input register, then counter update, winner pick and the
// result register.
// busy is high only in the first cycle after reset; it is low otherwise.
// The receiver cannot stall, so results leave on every done strobe.
// Reset clears all counts, sets the current state to off with aggressor
// class, and the allowed maximum to 5.
// ----------------------------------------------------------------------------
module power_state_vote_arbiter_core
    import psva_pkg::*;
#(
    parameter int STATE_COUNT = STATE_COUNT_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // vote item in
    input  logic               start,
    output logic               busy,
    input  logic [STATE_W-1:0] old_state,
    input  logic               old_aggressor,
    input  logic [STATE_W-1:0] new_state,
    input  logic               new_aggressor,
    // result out
    output logic               done,
    output logic [STATE_W-1:0] chosen_state,
    output logic               chosen_aggressor,
    output logic               change_issued,
    output logic [MUX_W-1:0]   mux_action,
    output logic               status,
    output logic               underflow,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [STATE_W-1:0] cfg_data
);

    logic                   busy_reg;
    vote_t                  vote_reg;
    vote_t                  vote_next;
    logic [STATE_W-1:0]     max_allowed_reg;
    logic [STATE_W-1:0]     cur_state_reg;
    logic [STATE_W-1:0]     cur_state_next;
    logic                   cur_aggr_reg;
    logic                   cur_aggr_next;

    logic [STATE_COUNT-1:0] aggr_live;
    logic [STATE_COUNT-1:0] pass_live;
    logic                   under;

    logic [STATE_W-1:0]     aggr_idx;
    logic                   aggr_any;
    logic [STATE_W-1:0]     pass_idx;
    logic [STATE_W-1:0]     win;
    logic                   win_aggr;
    logic                   issued;
    mux_action_t            mux;
    status_t                stat;

    logic                   done_reg;
    logic [STATE_W-1:0]     chosen_state_reg;
    logic                   chosen_aggr_reg;
    logic                   issued_reg;
    mux_action_t            mux_reg;
    status_t                status_reg;
    logic                   under_reg;

    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;

    // Input register
    always_comb
    begin
        vote_next.vld           = start && !busy_reg;
        vote_next.old_state     = old_state;
        vote_next.old_aggressor = old_aggressor;
        vote_next.new_state     = new_state;
        vote_next.new_aggressor = new_aggressor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b1;
            vote_reg        <= '0;
            max_allowed_reg <= MAX_ALLOWED_RST;
        end
        else
        begin
            busy_reg <= 1'b0;
            vote_reg <= vote_next;
            if (cfg_valid && cfg_ready)
            begin
                max_allowed_reg <= cfg_data;
            end
        end
    end

    // Counter banks
    psva_counts #(
        .STATE_COUNT (STATE_COUNT),
        .COUNT_BITS  (COUNT_BITS)
    ) u_counts (
        .clk       (clk),
        .rst_n     (rst_n),
        .vote      (vote_reg),
        .aggr_live (aggr_live),
        .pass_live (pass_live),
        .underflow (under)
    );

    // Highest live state in each class
    always_comb
    begin
        aggr_idx = STATE_OFF;
        aggr_any = 1'b0;
        pass_idx = STATE_OFF;
        for (int i = 0; i < STATE_COUNT; i++)
        begin
            if (aggr_live[i])
            begin
                aggr_idx = STATE_W'(i);
                aggr_any = 1'b1;
            end
            if (pass_live[i])
            begin
                pass_idx = STATE_W'(i);
            end
        end
    end

    // Winner and request decision
    always_comb
    begin
        win            = aggr_any ? aggr_idx : pass_idx;
        win_aggr       = aggr_any;
        issued         = 1'b0;
        mux            = MUX_NONE;
        stat           = STATUS_OK;
        cur_state_next = cur_state_reg;
        cur_aggr_next  = cur_aggr_reg;
        if (win > max_allowed_reg)
        begin
            stat = STATUS_INVALID;
        end
        else if ((win != cur_state_reg) || (win_aggr != cur_aggr_reg))
        begin
            if (win != STATE_OFF)
            begin
                issued = 1'b1;
                if (cur_state_reg == STATE_READY)
                begin
                    mux = MUX_NORMAL;
                end
                else if (win == STATE_READY)
                begin
                    mux = MUX_LOW;
                end
            end
            cur_state_next = win;
            cur_aggr_next  = win_aggr;
        end
    end

    // Current request and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_state_reg <= STATE_OFF;
            cur_aggr_reg  <= 1'b1;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= vote_reg.vld;
            if (vote_reg.vld)
            begin
                cur_state_reg <= cur_state_next;
                cur_aggr_reg  <= cur_aggr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (vote_reg.vld)
        begin
            chosen_state_reg <= win;
            chosen_aggr_reg  <= win_aggr;
            issued_reg       <= issued;
            mux_reg          <= mux;
            status_reg       <= stat;
            under_reg        <= under;
        end
    end

    assign done             = done_reg;
    assign chosen_state     = chosen_state_reg;
    assign chosen_aggressor = chosen_aggr_reg;
    assign change_issued    = issued_reg;
    assign mux_action       = mux_reg;
    assign status           = status_reg;
    assign underflow        = under_reg;

endmodule

// File: bench/tb_power_state_vote_arbiter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_power_state_vote_arbiter_core
// Self-checking bench for the power-state vote arbiter. Vote items go in on
// the start/busy handshake. A tally board keeps its own vote counts, current
// request and allowed maximum, and works out the outcome of every accepted
// item. Each done strobe is compared field by field with the oldest outcome
// still waiting. The run has a directed opening and random phases with mixed
// sender gaps and allowed-maximum values.
// ----------------------------------------------------------------------------
module tb_power_state_vote_arbiter_core;
    import psva_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int ITEMS_EACH = 250;

    // One outcome of a vote item
    typedef struct packed {
        logic [STATE_W-1:0] chosen_state;
        logic               chosen_aggressor;
        logic               change_issued;
        mux_action_t        mux;
        status_t            status;
        logic               underflow;
    } vote_outcome_t;

    // Vote tally board: own copy of the counts and request, outcomes queued
    class vote_tally_board;
        logic [COUNT_BITS_DEF-1:0] tally [2][STATE_COUNT_DEF];
        logic [STATE_W-1:0]        req_state = STATE_OFF;
        logic                      req_aggr  = 1'b1;
        logic [STATE_W-1:0]        allowed_max = MAX_ALLOWED_RST;
        vote_outcome_t             outstanding[$];
        int n_votes     = 0;
        int n_checked   = 0;
        int n_bad       = 0;
        int n_invalid   = 0;
        int n_underflow = 0;
        int n_changes   = 0;

        function new();
            foreach (tally[c, s])
                tally[c][s] = '0;
        endfunction

        function void set_max(logic [STATE_W-1:0] v);
            allowed_max = v;
        endfunction

        function int waiting();
            return outstanding.size();
        endfunction

        function string show(vote_outcome_t o);
            return $sformatf("state %0d aggr %b change %b mux %0d status %0d uflow %b",
                             o.chosen_state, o.chosen_aggressor, o.change_issued,
                             o.mux, o.status, o.underflow);
        endfunction

        // Apply an accepted vote and queue the outcome it must give
        function void note_vote(logic [STATE_W-1:0] os, logic oa,
                                logic [STATE_W-1:0] ns, logic na);
            vote_outcome_t      o;
            logic [STATE_W-1:0] win;
            logic               win_aggr;
            int                 s;
            o.underflow     = 1'b0;
            o.change_issued = 1'b0;
            o.mux           = MUX_NONE;
            o.status        = STATUS_OK;
            // withdrawal; off and out-of-table indexes are ignored
            if (os != STATE_OFF && os < STATE_COUNT_DEF)
            begin
                if (tally[oa][os] == '0)
                    o.underflow = 1'b1;
                else
                    tally[oa][os] = tally[oa][os] - 1'b1;
            end
            // new vote, saturating
            if (ns != STATE_OFF && ns < STATE_COUNT_DEF && tally[na][ns] != '1)
                tally[na][ns] = tally[na][ns] + 1'b1;
            // aggressor class wins first, then the passive class, else off
            win      = STATE_OFF;
            win_aggr = 1'b0;
            for (s = STATE_COUNT_DEF - 1; s > 0; s--)
            begin
                if (win == STATE_OFF && tally[1][s] != '0)
                begin
                    win      = STATE_W'(s);
                    win_aggr = 1'b1;
                end
            end
            for (s = STATE_COUNT_DEF - 1; s > 0; s--)
            begin
                if (win == STATE_OFF && tally[0][s] != '0)
                    win = STATE_W'(s);
            end
            // request update
            if (win > allowed_max)
                o.status = STATUS_INVALID;
            else if (win != req_state || win_aggr != req_aggr)
            begin
                if (win != STATE_OFF)
                begin
                    o.change_issued = 1'b1;
                    if (req_state == STATE_READY)
                        o.mux = MUX_NORMAL;
                    else if (win == STATE_READY)
                        o.mux = MUX_LOW;
                end
                req_state = win;
                req_aggr  = win_aggr;
            end
            o.chosen_state     = win;
            o.chosen_aggressor = win_aggr;
            n_votes++;
            if (o.status == STATUS_INVALID)
                n_invalid++;
            if (o.underflow)
                n_underflow++;
            if (o.change_issued)
                n_changes++;
            outstanding.push_back(o);
        endfunction

        // Compare one result with the oldest outcome waiting
        function void check_outcome(vote_outcome_t got);
            vote_outcome_t want;
            if (outstanding.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: result with no vote outstanding: %s", $realtime, show(got));
                return;
            end
            want = outstanding.pop_front();
            n_checked++;
            if (got.chosen_state !== want.chosen_state ||
                got.chosen_aggressor !== want.chosen_aggressor ||
                got.change_issued !== want.change_issued ||
                got.mux !== want.mux ||
                got.status !== want.status ||
                got.underflow !== want.underflow)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: result %0d wrong\n  expected %s\n  actual   %s",
                             $realtime, n_checked, show(want), show(got));
            end
        endfunction

        // Anything still queued at the end never came out
        function void close_out();
            if (outstanding.size() != 0)
            begin
                $display("%0d results never arrived", outstanding.size());
                n_bad += outstanding.size();
            end
        endfunction
    endclass

    logic               clk              = 1'b0;
    logic               rst_n            = 1'b0;
    logic               start            = 1'b0;
    logic [STATE_W-1:0] old_state        = '0;
    logic               old_aggressor    = 1'b0;
    logic [STATE_W-1:0] new_state        = '0;
    logic               new_aggressor    = 1'b0;
    logic               cfg_valid        = 1'b0;
    logic [STATE_W-1:0] cfg_data         = '0;
    logic               busy;
    logic               done;
    logic [STATE_W-1:0] chosen_state;
    logic               chosen_aggressor;
    logic               change_issued;
    logic [MUX_W-1:0]   mux_action;
    logic               status;
    logic               underflow;
    logic               cfg_ready;

    vote_tally_board    board;
    vote_outcome_t      seen;
    logic [3:0]         cast_pool[$];

    power_state_vote_arbiter_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .old_state        (old_state),
        .old_aggressor    (old_aggressor),
        .new_state        (new_state),
        .new_aggressor    (new_aggressor),
        .done             (done),
        .chosen_state     (chosen_state),
        .chosen_aggressor (chosen_aggressor),
        .change_issued    (change_issued),
        .mux_action       (mux_action),
        .status           (status),
        .underflow        (underflow),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Result monitor: a strobe is taken at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen.chosen_state     = chosen_state;
            seen.chosen_aggressor = chosen_aggressor;
            seen.change_issued    = change_issued;
            seen.mux              = mux_action_t'(mux_action);
            seen.status           = status_t'(status);
            seen.underflow        = underflow;
            board.check_outcome(seen);
        end
    end

    // Present one vote and hold it until taken; start stays high afterwards
    task automatic send_vote(input logic [STATE_W-1:0] os, input logic oa,
                             input logic [STATE_W-1:0] ns, input logic na);
        start         <= 1'b1;
        old_state     <= os;
        old_aggressor <= oa;
        new_state     <= ns;
        new_aggressor <= na;
        do
            @(posedge clk);
        while (busy);
        board.note_vote(os, oa, ns, na);
    endtask

    // Stop sending and let every outstanding result come out
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (board.waiting() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max(input logic [STATE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_max(v);
    endtask

    // Mostly matched cast/withdraw pairs from a small pool, some raw noise
    task automatic random_vote();
        logic [STATE_W-1:0] os;
        logic [STATE_W-1:0] ns;
        logic               oa;
        logic               na;
        int                 k;
        if ($urandom_range(99) < 80)
        begin
            os = STATE_OFF;
            oa = 1'($urandom_range(1));
            if (cast_pool.size() > $urandom_range(4))
            begin
                k  = $urandom_range(cast_pool.size() - 1);
                os = cast_pool[k][3:1];
                oa = cast_pool[k][0];
                cast_pool.delete(k);
            end
            ns = STATE_W'($urandom_range(STATE_COUNT_DEF - 1));
            na = 1'($urandom_range(1));
            if (ns != STATE_OFF)
                cast_pool.push_back({ns, na});
        end
        else
        begin
            os = STATE_W'($urandom_range(7));
            oa = 1'($urandom_range(1));
            ns = STATE_W'($urandom_range(7));
            na = 1'($urandom_range(1));
        end
        send_vote(os, oa, ns, na);
    endtask

    // Random phase; sender gaps per cycle, with occasional gap-free bursts
    task automatic run_random(input int n, input int idle_pct);
        int burst_left;
        int i;
        burst_left = 0;
        for (i = 0; i < n; i++)
        begin
            if (burst_left == 0 && $urandom_range(99) < 5)
                burst_left = $urandom_range(10, 40);
            if (burst_left > 0)
                burst_left--;
            else
            begin
                while ($urandom_range(99) < idle_pct)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                end
            end
            random_vote();
        end
    endtask

    // Watchdog
    initial
    begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Main sequence
    initial
    begin
        int idle_pct [6];
        int max_set  [6];
        int p;
        idle_pct = '{0, 51, 34, 0, 51, 34};
        max_set  = '{0, 3, 5, 1, 4, 2};
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: class flips, mux actions, underflow, out-of-table votes
        send_vote(3'd0, 1'b0, 3'd0, 1'b0);   // off winner, class flips
        send_vote(3'd3, 1'b0, 3'd1, 1'b0);   // withdraw from empty; enter ready
        send_vote(3'd0, 1'b0, 3'd5, 1'b0);   // leave ready
        send_vote(3'd0, 1'b0, 3'd2, 1'b1);   // aggressor beats higher passive
        send_vote(3'd6, 1'b1, 3'd7, 1'b1);   // indexes beyond the table
        send_vote(3'd7, 1'b0, 3'd6, 1'b0);
        send_vote(3'd2, 1'b1, 3'd4, 1'b1);
        send_vote(3'd4, 1'b1, 3'd0, 1'b1);   // back to passive winner
        send_vote(3'd5, 1'b0, 3'd0, 1'b1);   // down to ready
        send_vote(3'd1, 1'b0, 3'd0, 1'b0);   // off, no change issued
        send_vote(3'd1, 1'b0, 3'd1, 1'b1);   // underflow, ready aggressor
        send_vote(3'd1, 1'b1, 3'd3, 1'b0);
        send_vote(3'd3, 1'b0, 3'd3, 1'b0);   // no change
        send_vote(3'd7, 1'b1, 3'd5, 1'b1);
        settle();
        write_max(3'd2);
        send_vote(3'd0, 1'b0, 3'd0, 1'b0);   // winner above maximum
        send_vote(3'd5, 1'b1, 3'd2, 1'b0);
        send_vote(3'd3, 1'b0, 3'd0, 1'b0);   // allowed again
        send_vote(3'd2, 1'b0, 3'd0, 1'b0);
        settle();
        write_max(3'd0);
        send_vote(3'd0, 1'b1, 3'd1, 1'b1);
        send_vote(3'd1, 1'b1, 3'd0, 1'b0);
        settle();

        // Random phases
        for (p = 0; p < 6; p++)
        begin
            write_max(STATE_W'(max_set[p]));
            run_random(ITEMS_EACH, idle_pct[p]);
            settle();
        end

        board.close_out();
        $display("%0d votes, %0d results checked: %0d changes, %0d invalid, %0d underflows",
                 board.n_votes, board.n_checked, board.n_changes, board.n_invalid,
                 board.n_underflow);
        $display("allowed maximum swept 0..5 over the random phases, %0d bad results",
                 board.n_bad);
        if (board.n_bad == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
